@@ design/cacorr_pkg.sv @@
`timescale 1ns / 1ps

package cacorr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LAG_W       = 10;
   localparam int LEN_W       = 11;
   localparam int SUM_W       = 42;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_CALC = 1'b1
   } opcode_type;

   typedef enum logic {
      STAT_OK      = 1'b0,
      STAT_BAD_LAG = 1'b1
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic store;   // write sample at the write pointer
      logic start;   // latch lag, clear accumulator, set up indexes
      logic step;    // issue one pair of reads, advance indexes
      logic emit;    // move result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bad_lag;   // latched lag not below length
      logic last;      // current index pair is the final one
      logic busy;      // MAC pipeline still holds work
      logic rsp_free;  // output register can take a word this cycle
   } sts_type;

endpackage

@@ design/cacorr_ctrl.sv @@
`timescale 1ns / 1ps

module cacorr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  cacorr_pkg::opcode_type opcode,
   input  cacorr_pkg::sts_type sts,
   output cacorr_pkg::cmd_type cmd
);
   import cacorr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (opcode == OP_LOAD) begin
                  cmd.store = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (sts.bad_lag) begin
               state_in = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               if (sts.last) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.busy) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.store, cmd.start, cmd.step, cmd.emit}))
      else $error("controller issued more than one command");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("result emitted into a full output register");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> !sts.busy)
      else $error("result stage reached with MAC pipeline busy");

endmodule

@@ design/cacorr_dp.sv @@
`timescale 1ns / 1ps

module cacorr_dp #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [cacorr_pkg::SAMPLE_W-1:0] sample_value,
   input  logic [cacorr_pkg::LAG_W-1:0]         lag,
   input  logic                                 csr_valid,
   input  logic [cacorr_pkg::LEN_W-1:0]         csr_data,
   input  cacorr_pkg::cmd_type                  cmd,
   output cacorr_pkg::sts_type                  sts,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cacorr_pkg::SUM_W-1:0]         rsp_sum,
   output cacorr_pkg::status_type               rsp_status
);
   import cacorr_pkg::*;

   localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int EFF_W  = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;
   localparam logic [EFF_W-1:0] MAX_LEN = EFF_W'(MAX_SAMPLES);

   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [LEN_W-1:0]  len_ff;
   logic [EFF_W-1:0]  eff_len;
   logic [ADDR_W-1:0] wp_ff, wp_in, wr_addr;
   logic [EFF_W-1:0]  wp_next;
   logic [LAG_W-1:0]  lag_ff;
   logic              lag_bad;
   logic [ADDR_W-1:0] i_ff, j_ff;
   logic [EFF_W-1:0]  i_next, j_next;
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic              v1_ff, v2_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   status_type        rsp_status_ff;

   // length of zero acts as one, anything above capacity is clamped
   always_comb begin
      eff_len = EFF_W'(len_ff);
      if (len_ff == '0) eff_len = EFF_W'(1);
      else if (eff_len > MAX_LEN) eff_len = MAX_LEN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         len_ff <= csr_data;
      end
   end

   // write pointer may sit past a lowered length: wrap before storing
   always_comb begin
      wr_addr = wp_ff;
      if (EFF_W'(wp_ff) >= eff_len) wr_addr = '0;
      wp_next = EFF_W'(wr_addr) + EFF_W'(1);
      wp_in   = (wp_next >= eff_len) ? '0 : ADDR_W'(wp_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (cmd.store) begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wr_addr] <= sample_value;
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[i_ff];
      rd_b_ff <= mem[j_ff];
   end

   assign i_next = EFF_W'(i_ff) + EFF_W'(1);
   assign j_next = EFF_W'(j_ff) + EFF_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lag_ff <= lag;
         i_ff   <= '0;
         j_ff   <= ADDR_W'(lag);
      end else if (cmd.step) begin
         i_ff <= ADDR_W'(i_next);
         j_ff <= (j_next >= eff_len) ? '0 : ADDR_W'(j_next);
      end
   end

   assign lag_bad = (EFF_W'(lag_ff) >= eff_len);

   always_ff @(posedge clock) begin
      prod_ff <= rd_a_ff * rd_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.step;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sum_ff    <= lag_bad ? '0 : acc_ff;
         rsp_status_ff <= lag_bad ? STAT_BAD_LAG : STAT_OK;
      end
   end

   assign sts.bad_lag  = lag_bad;
   assign sts.last     = (i_next == eff_len);
   assign sts.busy     = v1_ff || v2_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("output word not presented after emit");

   a_step_good_lag: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !lag_bad)
      else $error("MAC step issued for an out-of-range lag");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (EFF_W'(i_ff) < eff_len) && (EFF_W'(j_ff) < eff_len))
      else $error("sample index beyond signal length");

endmodule

@@ design/circular_autocorrelation_top.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: opcode; tdata: sample_value, lag
// rsp      out  rsp_tvalid/rsp_tready  tuser: status; tdata: correlation_sum
// csr      in   csr_valid/csr_ready    csr_data: signal_length
//
// A load word stores one sample. A lag word reads one pair from the two-port
// sample memory per cycle into a single MAC, then drains the pipeline; an
// out-of-range lag skips the reads and goes straight to the result stage.
// Synchronous active-high reset clears the write pointer and sets length 1024;
// sample memory is not cleared. A stalled rsp word waits in the output register
// while the next request is taken; a new result waits only if it is still full.

module circular_autocorrelation_top #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_value, [25:16] lag, rest zero
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [41:0] correlation_sum, rest zero
   output logic        rsp_tuser,   // [0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data     // [10:0] signal_length
);
   import cacorr_pkg::*;

   cmd_type                    cmd;
   sts_type                    sts;
   opcode_type                 opcode;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic [LAG_W-1:0]           lag;
   logic [SUM_W-1:0]           rsp_sum;
   status_type                 rsp_status;

   assign opcode       = opcode_type'(req_tuser);
   assign sample_value = req_tdata[SAMPLE_W-1:0];
   assign lag          = req_tdata[SAMPLE_W +: LAG_W];
   assign csr_ready    = 1'b1;
   assign rsp_tdata    = {{(RSP_DATA_W-SUM_W){1'b0}}, rsp_sum};
   assign rsp_tuser    = rsp_status;

   cacorr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   cacorr_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .sample_value (sample_value),
      .lag          (lag),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_sum      (rsp_sum),
      .rsp_status   (rsp_status)
   );

endmodule
